FILE: hw/rtl/cqe_pkg.sv
`default_nettype none

package cqe_pkg;

  localparam int unsigned Depth     = 16;
  localparam int unsigned IdxBits   = $clog2(Depth);
  localparam int unsigned LenBits   = IdxBits + 1;
  localparam int unsigned DataBits  = 64;
  localparam int unsigned ModeBits  = 3;
  localparam int unsigned SlotBits  = 4;
  localparam int unsigned CountBits = 5;
  localparam int unsigned CapBits   = 5;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic [ModeBits-1:0] {
    OP_PUSH       = 3'd0,
    OP_RESERVE    = 3'd1,
    OP_SLOT_WRITE = 3'd2,
    OP_FRONT      = 3'd3,
    OP_BACK       = 3'd4,
    OP_POP        = 3'd5,
    OP_DRAIN      = 3'd6,
    OP_CLEAR      = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    BACK_EXEC,
    BACK_READ,
    BACK_DRAIN
  } back_state_e;

  typedef struct packed {
    logic [ModeBits-1:0]  mode;
    logic [DataBits-1:0]  data;
    logic [SlotBits-1:0]  slot;
    logic [CountBits-1:0] count;
  } in_item_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [DataBits-1:0]  entry;
    logic [SlotBits-1:0]  slot_index;
    logic [LenBits-1:0]   drained;
    logic                 last;
  } out_item_t;

  typedef struct packed {
    op_e                  op;
    logic [DataBits-1:0]  data;
    logic [SlotBits-1:0]  slot;
    logic [CountBits-1:0] count;
  } req_t;

endpackage

`default_nettype wire

FILE: hw/rtl/cqe_front.sv
`default_nettype none

module cqe_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire cqe_pkg::in_item_t in_item_i,
  output logic                   req_valid_o,
  input  wire logic              req_ready_i,
  output cqe_pkg::req_t          req_o
);
  import cqe_pkg::*;

  req_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  req_t       req_new;

  // Decode the mode and keep the data word only for operations that store it.
  always_comb begin
    req_new       = '0;
    req_new.slot  = in_item_i.slot;
    req_new.count = in_item_i.count;
    unique case (in_item_i.mode)
      OP_PUSH:       begin req_new.op = OP_PUSH;       req_new.data = in_item_i.data; end
      OP_RESERVE:    req_new.op = OP_RESERVE;
      OP_SLOT_WRITE: begin req_new.op = OP_SLOT_WRITE; req_new.data = in_item_i.data; end
      OP_FRONT:      req_new.op = OP_FRONT;
      OP_BACK:       req_new.op = OP_BACK;
      OP_POP:        req_new.op = OP_POP;
      OP_DRAIN:      req_new.op = OP_DRAIN;
      default:       req_new.op = OP_CLEAR;
    endcase
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign req_valid_o = (cnt_q != 2'd0);
  assign req_o       = entry_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = req_valid_o && req_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    unique case ({push, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= req_new;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/cqe_back.sv
`default_nettype none

module cqe_back (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [cqe_pkg::CapBits-1:0]     cfg_data_i,
  input  wire logic                            req_valid_i,
  output logic                                 req_ready_o,
  input  wire cqe_pkg::req_t                   req_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output cqe_pkg::out_item_t                   out_item_o
);
  import cqe_pkg::*;

  // Reduces base + off modulo cap by subtracting cap times 16, 8, 4, 2 and 1.
  function automatic logic [IdxBits-1:0] wrap_pos(logic [IdxBits-1:0] base,
                                                  logic [LenBits-1:0] off,
                                                  logic [LenBits-1:0] cap);
    logic [LenBits+IdxBits-1:0] sum;
    logic [LenBits+IdxBits-1:0] step;
    sum = (LenBits+IdxBits)'(base) + (LenBits+IdxBits)'(off);
    for (int k = IdxBits; k >= 0; k--) begin
      step = (LenBits+IdxBits)'(cap) << k;
      if (sum >= step) begin
        sum = sum - step;
      end
    end
    return sum[IdxBits-1:0];
  endfunction

  logic [DataBits-1:0] mem_q [Depth];
  logic [DataBits-1:0] rdata_q;
  logic                mem_we, mem_re;
  logic [IdxBits-1:0]  mem_waddr, mem_raddr;

  back_state_e         state_q, state_d;
  logic [LenBits-1:0]  cap_q, cap_d;
  logic [IdxBits-1:0]  head_q, head_d;
  logic [LenBits-1:0]  len_q, len_d;
  logic [LenBits-1:0]  rem_q, rem_d;
  logic [LenBits-1:0]  total_q, total_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_q, out_d;
  out_item_t           res;
  logic                out_free;
  logic [LenBits-1:0]  cap_new;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    if (cfg_data_i == '0) begin
      cap_new = LenBits'(1);
    end else if (LenBits'(cfg_data_i) > LenBits'(Depth)) begin
      cap_new = LenBits'(Depth);
    end else begin
      cap_new = LenBits'(cfg_data_i);
    end
  end

  always_comb begin
    state_d     = state_q;
    cap_d       = cap_q;
    head_d      = head_q;
    len_d       = len_q;
    rem_d       = rem_q;
    total_d     = total_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    req_ready_o = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = head_q;
    mem_raddr   = head_q;
    res         = '0;
    res.last    = 1'b1;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      BACK_EXEC: begin
        if (req_valid_i && out_free) begin
          req_ready_o = 1'b1;
          unique case (req_i.op)
            OP_PUSH: begin
              if (len_q >= cap_q) begin
                res.status = STATUS_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = wrap_pos(head_q, len_q, cap_q);
                len_d     = len_q + LenBits'(1);
              end
            end
            OP_RESERVE: begin
              if (len_q >= cap_q) begin
                res.status = STATUS_FULL;
              end else begin
                res.slot_index = len_q[SlotBits-1:0];
                len_d          = len_q + LenBits'(1);
              end
            end
            OP_SLOT_WRITE: begin
              mem_we    = 1'b1;
              mem_waddr = wrap_pos(head_q, LenBits'(req_i.slot), cap_q);
            end
            OP_FRONT: begin
              if (len_q == '0) begin
                res.status = STATUS_EMPTY;
              end else begin
                mem_re  = 1'b1;
                state_d = BACK_READ;
              end
            end
            OP_BACK: begin
              if (len_q == '0) begin
                res.status = STATUS_EMPTY;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = wrap_pos(head_q, len_q - LenBits'(1), cap_q);
                state_d   = BACK_READ;
              end
            end
            OP_POP: begin
              if (LenBits'(req_i.count) > len_q) begin
                res.status = STATUS_EMPTY;
              end else begin
                len_d  = len_q - LenBits'(req_i.count);
                head_d = wrap_pos(head_q, LenBits'(req_i.count), cap_q);
              end
            end
            OP_DRAIN: begin
              if (len_q == '0) begin
                res.status = STATUS_EMPTY;
              end else begin
                mem_re  = 1'b1;
                head_d  = wrap_pos(head_q, LenBits'(1), cap_q);
                rem_d   = len_q;
                total_d = len_q;
                len_d   = '0;
                state_d = BACK_DRAIN;
              end
            end
            default: begin
              head_d = '0;
              len_d  = '0;
            end
          endcase
          if (state_d == BACK_EXEC) begin
            out_valid_d = 1'b1;
            out_d       = res;
          end
        end
      end
      BACK_READ: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = res;
          out_d.entry = rdata_q;
          state_d     = BACK_EXEC;
        end
      end
      BACK_DRAIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = res;
          out_d.entry = rdata_q;
          if (rem_q == LenBits'(1)) begin
            out_d.drained = total_q;
            state_d       = BACK_EXEC;
          end else begin
            // Fetch the next entry while this one goes out.
            out_d.last = 1'b0;
            mem_re     = 1'b1;
            head_d     = wrap_pos(head_q, LenBits'(1), cap_q);
            rem_d      = rem_q - LenBits'(1);
          end
        end
      end
      default: state_d = BACK_EXEC;
    endcase

    if (cfg_we_i) begin
      cap_d  = cap_new;
      head_d = '0;
      len_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BACK_EXEC;
      cap_q       <= LenBits'(Depth);
      head_q      <= '0;
      len_q       <= '0;
      rem_q       <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cap_q       <= cap_d;
      head_q      <= head_d;
      len_q       <= len_d;
      rem_q       <= rem_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= req_i.data;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/circular_queue_engine.sv
`default_nettype none

// Ring-buffer queue of 16 entries of 64 bits, of which the configured capacity
// (1 to 16) is used; writing the capacity empties the queue. Requests enter a
// two-entry queue and are executed one at a time by the back end, which owns
// the entry memory and a result register. Push, reserve, slot write, pop and
// clear produce their result directly; front and back first pass through a read
// state because the memory read data is registered; a drain of n entries
// produces one result per entry, and no other request is executed meanwhile. Every
// request yields at least one result, and the last one of its run has last set.
module circular_queue_engine (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [cqe_pkg::CapBits-1:0] cfg_data_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire cqe_pkg::in_item_t           in_item_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output cqe_pkg::out_item_t               out_item_o
);
  import cqe_pkg::*;

  logic req_valid;
  logic req_ready;
  req_t req;

  cqe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .req_valid_o (req_valid),
    .req_ready_i (req_ready),
    .req_o       (req)
  );

  cqe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .req_i       (req),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/cqe_checker.sv
`default_nettype none

module cqe_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire cqe_pkg::out_item_t out_item_o
);
  import cqe_pkg::*;

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_item_o))
    else $error("result changed while stalled");

  // Only drain produces results that are not the last of a run, always with ok status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.last |->
      out_item_o.status == STATUS_OK && out_item_o.drained == '0 &&
      out_item_o.slot_index == '0)
    else $error("malformed intermediate drain result");

  // A granted slot comes with no entry data and no drain count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.slot_index != '0 |->
      out_item_o.entry == '0 && out_item_o.drained == '0 &&
      out_item_o.status == STATUS_OK)
    else $error("reserve result carries other fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != STATUS_OK |->
      out_item_o.entry == '0 && out_item_o.drained == '0 && out_item_o.last)
    else $error("error result carries data");

endmodule

bind circular_queue_engine cqe_checker u_cqe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire
